// ===== design/mbe_pkg.sv =====
// ----------------------------------------------------------------------------
// mbe_pkg
// shared types, register indexes and fixed point helpers for the escape-time
// pixel engine
// ----------------------------------------------------------------------------
package mbe_pkg;

	localparam int FRACTION_BITS_DEF = 24;
	localparam int QUEUE_DEPTH_DEF   = 2;

	localparam int COORD_W = 32;
	localparam int COUNT_W = 12;
	localparam int BAIL_W  = 31;
	localparam int COL_W   = 10;
	localparam int ROW_W   = 10;
	localparam int COLOR_W = 3;
	localparam int IDX_W   = 3;
	localparam int WDATA_W = 32;

	// configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_REAL_ORIGIN = 3'd0,
		REG_REAL_STEP   = 3'd1,
		REG_IMAG_ORIGIN = 3'd2,
		REG_IMAG_STEP   = 3'd3,
		REG_ITER_LIMIT  = 3'd4,
		REG_BAILOUT     = 3'd5
	} reg_idx_t;

	// point c handed from the front to the iteration core
	typedef struct packed {
		logic signed [COORD_W-1:0] cr;
		logic signed [COORD_W-1:0] ci;
	} point_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_UPD
	} core_state_t;

	// clamp a wide signed value to the 32-bit range
	function automatic logic signed [COORD_W-1:0] sat32(input logic signed [63:0] v);
		logic hi_same;
		hi_same = (&v[63:COORD_W-1]) | ~(|v[63:COORD_W-1]);
		if (hi_same)
			return v[COORD_W-1:0];
		else if (v[63])
			return {1'b1, {(COORD_W-1){1'b0}}};
		else
			return {1'b0, {(COORD_W-1){1'b1}}};
	endfunction

endpackage

// ===== design/mbe_front.sv =====
// ----------------------------------------------------------------------------
// mbe_front
// maps a pixel column and signed row onto the point c in fixed point
// ----------------------------------------------------------------------------
module mbe_front (
	input  logic [mbe_pkg::COL_W-1:0]          column,
	input  logic signed [mbe_pkg::ROW_W-1:0]   row,
	input  logic signed [mbe_pkg::COORD_W-1:0] real_origin,
	input  logic signed [mbe_pkg::COORD_W-1:0] real_step,
	input  logic signed [mbe_pkg::COORD_W-1:0] imag_origin,
	input  logic signed [mbe_pkg::COORD_W-1:0] imag_step,
	output mbe_pkg::point_t                    point
);

	logic signed [mbe_pkg::COL_W:0] col_s;
	logic signed [63:0]             re_sum;
	logic signed [63:0]             im_sum;

	// column is unsigned, give it a zero sign bit
	assign col_s  = {1'b0, column};
	assign re_sum = 64'(real_origin) + 64'(col_s) * 64'(real_step);
	assign im_sum = 64'(imag_origin) + 64'(row) * 64'(imag_step);

	assign point.cr = mbe_pkg::sat32(re_sum);
	assign point.ci = mbe_pkg::sat32(im_sum);

endmodule

// ===== design/mbe_queue.sv =====
// ----------------------------------------------------------------------------
// mbe_queue
// small word queue between the mapping front and the iteration core
// ----------------------------------------------------------------------------
module mbe_queue #(
	parameter int DEPTH = mbe_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  mbe_pkg::point_t wdata,
	output logic            full,
	input  logic            rd,
	output logic            valid,
	output mbe_pkg::point_t rdata
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [FW-1:0] FULL_CNT = FW'(DEPTH);

	mbe_pkg::point_t mem_q [DEPTH];
	logic [AW-1:0]   wptr_q;
	logic [AW-1:0]   rptr_q;
	logic [FW-1:0]   fill_q;
	logic            do_wr;
	logic            do_rd;

	assign full  = (fill_q == FULL_CNT);
	assign valid = (fill_q != '0);
	assign do_wr = wr & ~full;
	assign do_rd = rd & valid;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_wr)
				wptr_q <= (wptr_q == LAST) ? '0 : wptr_q + 1'b1;
			if (do_rd)
				rptr_q <= (rptr_q == LAST) ? '0 : rptr_q + 1'b1;
			if (do_wr && !do_rd)
				fill_q <= fill_q + 1'b1;
			else if (do_rd && !do_wr)
				fill_q <= fill_q - 1'b1;
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FULL_CNT)
		else $error("queue fill beyond depth");

endmodule

// ===== design/mbe_core.sv =====
// ----------------------------------------------------------------------------
// mbe_core
// iterates z = z^2 + c for one point and holds the finished count
// ----------------------------------------------------------------------------
module mbe_core #(
	parameter int FRACTION_BITS = mbe_pkg::FRACTION_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  mbe_pkg::point_t                   in_point,
	output logic                              in_take,
	input  logic [mbe_pkg::COUNT_W-1:0]       iteration_limit,
	input  logic [mbe_pkg::BAIL_W-1:0]        bailout_square,
	output logic                              res_valid,
	input  logic                              res_pop,
	output logic [mbe_pkg::COUNT_W-1:0]       res_count
);

	mbe_pkg::core_state_t state_q, state_nx;

	logic signed [mbe_pkg::COORD_W-1:0] x_q, y_q, cr_q, ci_q;
	logic [mbe_pkg::COUNT_W-1:0]        cnt_q;
	logic signed [63:0]                 pxx_s1, pyy_s1, pxy_s1;
	logic                               res_valid_q;
	logic [mbe_pkg::COUNT_W-1:0]        res_count_q;

	logic signed [mbe_pkg::COORD_W-1:0] xx, yy, xy, diff, x_nx, y_nx;
	logic [mbe_pkg::COORD_W:0]          mag_sum;
	logic [mbe_pkg::BAIL_W-1:0]         mag;
	logic [mbe_pkg::COUNT_W-1:0]        lim_eff, cnt_nx, fin_count;
	logic                               escape, limit_hit, done, stall;
	logic                               load, step, out_wr;

	// scaled squares of the current z, also its squared magnitude
	assign xx   = mbe_pkg::sat32(pxx_s1 >>> FRACTION_BITS);
	assign yy   = mbe_pkg::sat32(pyy_s1 >>> FRACTION_BITS);
	assign xy   = mbe_pkg::sat32(pxy_s1 >>> (FRACTION_BITS - 1));
	assign diff = mbe_pkg::sat32(64'(xx) - 64'(yy));
	assign x_nx = mbe_pkg::sat32(64'(diff) + 64'(cr_q));
	assign y_nx = mbe_pkg::sat32(64'(xy) + 64'(ci_q));

	assign mag_sum = {1'b0, xx} + {1'b0, yy};
	assign mag     = (mag_sum[mbe_pkg::COORD_W] | mag_sum[mbe_pkg::COORD_W-1]) ?
		{mbe_pkg::BAIL_W{1'b1}} : mag_sum[mbe_pkg::BAIL_W-1:0];

	// a zero limit acts as one
	assign lim_eff   = (iteration_limit == '0) ? mbe_pkg::COUNT_W'(1) : iteration_limit;
	assign cnt_nx    = cnt_q + 1'b1;
	// magnitude of z after the previous iteration, none before the first
	assign escape    = (cnt_q != '0) && (mag >= bailout_square);
	assign limit_hit = (cnt_nx >= lim_eff);
	assign done      = escape | limit_hit;
	assign fin_count = escape ? cnt_q : cnt_nx;
	assign stall     = res_valid_q & ~res_pop;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			mbe_pkg::ST_IDLE: begin
				if (in_valid)
					state_nx = mbe_pkg::ST_MUL;
			end
			mbe_pkg::ST_MUL: begin
				state_nx = mbe_pkg::ST_UPD;
			end
			mbe_pkg::ST_UPD: begin
				if (!done)
					state_nx = mbe_pkg::ST_MUL;
				else if (!stall)
					state_nx = mbe_pkg::ST_IDLE;
			end
			default: begin
				state_nx = mbe_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		load   = 1'b0;
		step   = 1'b0;
		out_wr = 1'b0;
		unique case (state_q)
			mbe_pkg::ST_IDLE: begin
				load = in_valid;
			end
			mbe_pkg::ST_MUL: begin
			end
			mbe_pkg::ST_UPD: begin
				step   = ~done;
				out_wr = done & ~stall;
			end
			default: begin
			end
		endcase
	end

	assign in_take   = load;
	assign res_valid = res_valid_q;
	assign res_count = res_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mbe_pkg::ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (out_wr)
				res_valid_q <= 1'b1;
			else if (res_pop)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cr_q  <= in_point.cr;
			ci_q  <= in_point.ci;
			x_q   <= '0;
			y_q   <= '0;
			cnt_q <= '0;
		end else if (step) begin
			x_q   <= x_nx;
			y_q   <= y_nx;
			cnt_q <= cnt_nx;
		end
		if (state_q == mbe_pkg::ST_MUL) begin
			pxx_s1 <= 64'(x_q) * 64'(x_q);
			pyy_s1 <= 64'(y_q) * 64'(y_q);
			pxy_s1 <= 64'(x_q) * 64'(y_q);
		end
		if (out_wr)
			res_count_q <= fin_count;
	end

	a_mul_then_upd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mbe_pkg::ST_MUL) |=> (state_q == mbe_pkg::ST_UPD))
		else $error("multiply cycle not followed by update");

	a_result_from_upd: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == mbe_pkg::ST_UPD))
		else $error("result appeared outside an update cycle");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_count_q != '0))
		else $error("result count is zero");

endmodule

// ===== design/mandelbrot_escape_time.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// escape-time pixel engine: pixel coordinates in, iteration count and color out
// ----------------------------------------------------------------------------
// A word pushed in carries a pixel column and signed row. The front maps it
// onto c = (real_origin + column*real_step, imag_origin + row*imag_step) and
// drops c into a short queue, so new pixels are taken while the core works.
// The core runs z = z^2 + c from zero. Each iteration passes through ST_MUL
// for the two 32x32 squares and the cross product, then ST_UPD for scaling,
// the bailout compare and the update of z. The core takes no new point until
// the current one has finished and its result is written. The default limit
// is 112; a pixel that escapes stays in the core longer than its count shows,
// as the magnitude of its last z is compared only after another multiply.
// The multiply and update loop sets the rate. Results come out of an output
// register in push order; the core holds a finished pixel until that
// register is free, which adds the cycles the result side stalls.
// Configuration writes are meant for idle time.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time #(
	parameter int FRACTION_BITS = mbe_pkg::FRACTION_BITS_DEF,
	parameter int QUEUE_DEPTH   = mbe_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// pixel words in
	input  logic                                push,
	output logic                                full,
	input  logic [mbe_pkg::COL_W-1:0]           column,
	input  logic signed [mbe_pkg::ROW_W-1:0]    row,
	// result words out
	output logic                                empty,
	input  logic                                pop,
	output logic [mbe_pkg::COUNT_W-1:0]         iteration_count,
	output logic [mbe_pkg::COLOR_W-1:0]         color_code,
	// register writes
	input  logic                                cfg_we,
	input  logic [mbe_pkg::IDX_W-1:0]           cfg_index,
	input  logic [mbe_pkg::WDATA_W-1:0]         cfg_wdata
);

	// reset values follow the fraction width
	localparam longint ONE_FIX  = longint'(1) << FRACTION_BITS;
	localparam longint S32_MAX  = 64'sd2147483647;
	localparam longint BO_FULL  = 11 * ONE_FIX;
	localparam logic signed [31:0] RO_RST = 32'(-2 * ONE_FIX);
	localparam logic signed [31:0] RS_RST = 32'((ONE_FIX + 15) / 30);
	localparam logic signed [31:0] IS_RST = 32'((ONE_FIX + 7) / 15);
	localparam logic [mbe_pkg::BAIL_W-1:0] BO_RST =
		mbe_pkg::BAIL_W'((BO_FULL > S32_MAX) ? S32_MAX : BO_FULL);
	localparam logic [mbe_pkg::COUNT_W-1:0] LIM_RST = mbe_pkg::COUNT_W'(112);

	logic signed [mbe_pkg::COORD_W-1:0] real_origin_q, real_step_q;
	logic signed [mbe_pkg::COORD_W-1:0] imag_origin_q, imag_step_q;
	logic [mbe_pkg::COUNT_W-1:0]        iter_limit_q;
	logic [mbe_pkg::BAIL_W-1:0]         bailout_q;

	mbe_pkg::point_t front_point, queue_point;
	logic            queue_valid, core_take, res_valid;
	logic [mbe_pkg::COUNT_W-1:0] res_count;

	// register file, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			real_origin_q <= RO_RST;
			real_step_q   <= RS_RST;
			imag_origin_q <= '0;
			imag_step_q   <= IS_RST;
			iter_limit_q  <= LIM_RST;
			bailout_q     <= BO_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mbe_pkg::REG_REAL_ORIGIN: real_origin_q <= cfg_wdata;
				mbe_pkg::REG_REAL_STEP:   real_step_q   <= cfg_wdata;
				mbe_pkg::REG_IMAG_ORIGIN: imag_origin_q <= cfg_wdata;
				mbe_pkg::REG_IMAG_STEP:   imag_step_q   <= cfg_wdata;
				mbe_pkg::REG_ITER_LIMIT:  iter_limit_q  <= cfg_wdata[mbe_pkg::COUNT_W-1:0];
				mbe_pkg::REG_BAILOUT:     bailout_q     <= cfg_wdata[mbe_pkg::BAIL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// coordinate mapping, combinational into the queue
	mbe_front u_front (
		.column      (column),
		.row         (row),
		.real_origin (real_origin_q),
		.real_step   (real_step_q),
		.imag_origin (imag_origin_q),
		.imag_step   (imag_step_q),
		.point       (front_point)
	);

	// decouples pixel intake from the iteration loop
	mbe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (push),
		.wdata  (front_point),
		.full   (full),
		.rd     (core_take),
		.valid  (queue_valid),
		.rdata  (queue_point)
	);

	// escape-time loop with its output register
	mbe_core #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (queue_valid),
		.in_point        (queue_point),
		.in_take         (core_take),
		.iteration_limit (iter_limit_q),
		.bailout_square  (bailout_q),
		.res_valid       (res_valid),
		.res_pop         (pop),
		.res_count       (res_count)
	);

	assign empty           = ~res_valid;
	assign iteration_count = res_count;
	// color is the low count bits: red, green, blue
	assign color_code      = res_count[mbe_pkg::COLOR_W-1:0];

endmodule
